>>> rtl/core/rwhp_pkg.sv
// ----------------------------------------------------------------------------
// rwhp_pkg
// Shared types and constants of the RIFF/WAVE header parser.
// ----------------------------------------------------------------------------
package rwhp_pkg;

	localparam logic [1:0] FN_BYTE    = 2'd0;
	localparam logic [1:0] FN_EOF     = 2'd1;
	localparam logic [1:0] FN_RESTART = 2'd2;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_NOT_WAVE  = 3'd1;
	localparam logic [2:0] ST_NOT_PCM   = 3'd2;
	localparam logic [2:0] ST_EARLY_EOF = 3'd3;
	localparam logic [2:0] ST_RIFF_EXH  = 3'd4;

	localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
	localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
	localparam logic [31:0] TAG_DATA = 32'h6174_6164;
	localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;

	localparam logic [15:0] FMT_PCM = 16'd1;

	typedef struct packed {
		logic [1:0] func;
		logic [7:0] data_byte;
	} rwhp_item_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [31:0] sample_rate;
		logic [15:0] channel_count;
		logic [15:0] block_align;
		logic [15:0] bits_per_sample;
		logic [31:0] data_offset;
		logic [31:0] data_size;
	} rwhp_result_t;

endpackage

>>> rtl/core/rwhp_core.sv
// ----------------------------------------------------------------------------
// rwhp_core
// Parser state and the per-byte update: header tags, chunk walk, fmt capture,
// RIFF size countdown and result selection.
// ----------------------------------------------------------------------------
module rwhp_core (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step,
	input  rwhp_pkg::rwhp_item_t  item,
	output logic                  res_valid,
	output rwhp_pkg::rwhp_result_t res
);

	localparam logic [1:0] PH_RIFF  = 2'd0;
	localparam logic [1:0] PH_CHUNK = 2'd1;
	localparam logic [1:0] PH_FMT   = 2'd2;
	localparam logic [1:0] PH_SKIP  = 2'd3;

	logic [1:0]  phase_q, phase_n;
	logic [31:0] pos_q, pos_n;
	logic [3:0]  idx_q, idx_n;
	logic [31:0] tag_q, tag_n;
	logic [31:0] size_q, size_n;
	logic [31:0] skip_q, skip_n;
	logic [31:0] riff_q, riff_n;
	logic [15:0] fmt_q, fmt_n;
	logic [31:0] rate_q, rate_n;
	logic [15:0] chan_q, chan_n;
	logic [15:0] align_q, align_n;
	logic [15:0] bits_q, bits_n;
	logic [31:0] offs_q, offs_n;
	logic [31:0] len_q, len_n;
	logic        fin_q, fin_n;

	logic [2:0]  status;
	logic        do_end;
	logic [31:0] end_skip;
	logic [32:0] used;
	logic [31:0] tag_sh;
	logic [31:0] size_sh;
	logic [7:0]  b;

	always_comb begin
		phase_n  = phase_q;
		pos_n    = pos_q;
		idx_n    = idx_q;
		tag_n    = tag_q;
		size_n   = size_q;
		skip_n   = skip_q;
		riff_n   = riff_q;
		fmt_n    = fmt_q;
		rate_n   = rate_q;
		chan_n   = chan_q;
		align_n  = align_q;
		bits_n   = bits_q;
		offs_n   = offs_q;
		len_n    = len_q;
		fin_n    = fin_q;
		res_valid = 1'b0;
		status   = rwhp_pkg::ST_OK;
		do_end   = 1'b0;
		end_skip = '0;
		used     = '0;
		b        = item.data_byte;
		tag_sh   = {b, tag_q[31:8]};
		size_sh  = {b, size_q[31:8]};

		if (step) begin
			if (item.func == rwhp_pkg::FN_RESTART) begin
				phase_n = PH_RIFF;
				pos_n   = '0;
				idx_n   = '0;
				tag_n   = '0;
				size_n  = '0;
				skip_n  = '0;
				riff_n  = '0;
				fmt_n   = '0;
				rate_n  = '0;
				chan_n  = '0;
				align_n = '0;
				bits_n  = '0;
				offs_n  = '0;
				len_n   = '0;
				fin_n   = 1'b0;
			end else if (item.func == rwhp_pkg::FN_EOF && !fin_q) begin
				res_valid = 1'b1;
				status    = rwhp_pkg::ST_EARLY_EOF;
			end else if (item.func == rwhp_pkg::FN_BYTE && !fin_q) begin
				pos_n = pos_q + 32'd1;
				idx_n = idx_q + 4'd1;
				case (phase_q)
					PH_RIFF: begin
						if (idx_q < 4'd4 || idx_q >= 4'd8) begin
							tag_n = tag_sh;
						end else begin
							size_n = size_sh;
						end
						if (idx_q == 4'd3 && tag_n != rwhp_pkg::TAG_RIFF) begin
							res_valid = 1'b1;
							status    = rwhp_pkg::ST_NOT_WAVE;
						end else if (idx_q >= 4'd11) begin
							if (tag_n != rwhp_pkg::TAG_WAVE) begin
								res_valid = 1'b1;
								status    = rwhp_pkg::ST_NOT_WAVE;
							end else begin
								riff_n  = size_n;
								idx_n   = '0;
								phase_n = PH_CHUNK;
								if (size_n == '0) begin
									res_valid = 1'b1;
									status    = rwhp_pkg::ST_RIFF_EXH;
								end
							end
						end
					end
					PH_CHUNK: begin
						if (idx_q < 4'd4) begin
							tag_n = tag_sh;
						end else begin
							size_n = size_sh;
						end
						if (idx_q >= 4'd7) begin
							idx_n = '0;
							if (tag_n == rwhp_pkg::TAG_DATA) begin
								offs_n = pos_n;
								len_n  = size_n;
								if (pos_n != '0 && rate_q != '0) begin
									res_valid = 1'b1;
								end else begin
									do_end   = 1'b1;
									end_skip = size_n;
								end
							end else if (tag_n == rwhp_pkg::TAG_FMT) begin
								phase_n = PH_FMT;
							end else begin
								do_end   = 1'b1;
								end_skip = size_n;
							end
						end
					end
					PH_FMT: begin
						case (idx_q)
							4'd0:  fmt_n[7:0]   = b;
							4'd1:  fmt_n[15:8]  = b;
							4'd2:  chan_n[7:0]  = b;
							4'd3:  chan_n[15:8] = b;
							4'd4:  rate_n[7:0]  = b;
							4'd5:  rate_n[15:8] = b;
							4'd6:  rate_n[23:16] = b;
							4'd7:  rate_n[31:24] = b;
							4'd12: align_n[7:0]  = b;
							4'd13: align_n[15:8] = b;
							4'd14: bits_n[7:0]   = b;
							4'd15: bits_n[15:8]  = b;
							default: ;
						endcase
						if (idx_q == 4'd15) begin
							idx_n = '0;
							if (fmt_n != rwhp_pkg::FMT_PCM) begin
								res_valid = 1'b1;
								status    = rwhp_pkg::ST_NOT_PCM;
							end else if (offs_q != '0 && rate_n != '0) begin
								res_valid = 1'b1;
							end else begin
								do_end   = 1'b1;
								end_skip = (size_q > 32'd16) ? size_q - 32'd16 : '0;
							end
						end
					end
					default: begin
						idx_n = idx_q;
						if (skip_q != '0) begin
							skip_n = skip_q - 32'd1;
						end
						if (skip_n == '0) begin
							phase_n = PH_CHUNK;
						end
					end
				endcase

				if (do_end) begin
					used = 33'd8 + {1'b0, size_n};
					if ({1'b0, riff_q} <= used) begin
						riff_n    = '0;
						res_valid = 1'b1;
						status    = rwhp_pkg::ST_RIFF_EXH;
					end else begin
						riff_n = riff_q - used[31:0];
						if (end_skip == '0) begin
							phase_n = PH_CHUNK;
						end else begin
							phase_n = PH_SKIP;
							skip_n  = end_skip;
						end
					end
				end
			end
		end

		if (res_valid) begin
			fin_n = 1'b1;
		end
	end

	always_comb begin
		res.status          = status;
		res.sample_rate     = (status == rwhp_pkg::ST_OK) ? rate_n  : '0;
		res.channel_count   = (status == rwhp_pkg::ST_OK) ? chan_n  : '0;
		res.block_align     = (status == rwhp_pkg::ST_OK) ? align_n : '0;
		res.bits_per_sample = (status == rwhp_pkg::ST_OK) ? bits_n  : '0;
		res.data_offset     = (status == rwhp_pkg::ST_OK) ? offs_n  : '0;
		res.data_size       = (status == rwhp_pkg::ST_OK) ? len_n   : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_RIFF;
			pos_q   <= '0;
			idx_q   <= '0;
			tag_q   <= '0;
			size_q  <= '0;
			skip_q  <= '0;
			riff_q  <= '0;
			fmt_q   <= '0;
			rate_q  <= '0;
			chan_q  <= '0;
			align_q <= '0;
			bits_q  <= '0;
			offs_q  <= '0;
			len_q   <= '0;
			fin_q   <= 1'b0;
		end else begin
			phase_q <= phase_n;
			pos_q   <= pos_n;
			idx_q   <= idx_n;
			tag_q   <= tag_n;
			size_q  <= size_n;
			skip_q  <= skip_n;
			riff_q  <= riff_n;
			fmt_q   <= fmt_n;
			rate_q  <= rate_n;
			chan_q  <= chan_n;
			align_q <= align_n;
			bits_q  <= bits_n;
			offs_q  <= offs_n;
			len_q   <= len_n;
			fin_q   <= fin_n;
		end
	end

	a_emit_sets_fin: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |=> fin_q)
		else $error("result given without marking finished");

	a_no_second_result: assert property (@(posedge clk) disable iff (!arst_n)
		fin_q |-> !res_valid)
		else $error("second result after finish");

	a_skip_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_SKIP) |-> (skip_q != '0))
		else $error("skip phase with nothing to skip");

	a_chunk_idx: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_CHUNK) |-> (idx_q < 4'd8))
		else $error("chunk header index out of range");

	a_fail_zero_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && status != rwhp_pkg::ST_OK) |->
		(res.sample_rate == '0 && res.data_offset == '0 && res.data_size == '0))
		else $error("failure result carries nonzero fields");

endmodule

>>> rtl/core/riff_wave_header_parser.sv
// ----------------------------------------------------------------------------
// riff_wave_header_parser
// Parses a little-endian WAV byte stream, one byte per input transfer, and
// gives at most one result per restart: OK with the fmt fields and the data
// chunk offset and size, or a failure code. The input tuser selects byte,
// end of file or restart. One byte is taken every cycle while the output is
// not stalled; the byte that completes a result passes the input register and
// the combinational byte update of the parser state, and the result is then
// held in the output register.
// ----------------------------------------------------------------------------
module riff_wave_header_parser (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [7:0]   s_tdata,   // [7:0] data_byte
	input  logic [1:0]   s_tuser,   // [1:0] func
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [143:0] m_tdata,   // [31:0] sample_rate, [47:32] channel_count,
	                                // [63:48] block_align, [79:64] bits_per_sample,
	                                // [111:80] data_offset, [143:112] data_size
	output logic [2:0]   m_tuser    // [2:0] status
);

	logic                   valid_s1;
	rwhp_pkg::rwhp_item_t   item_s1;
	logic                   advance;
	logic                   res_valid;
	rwhp_pkg::rwhp_result_t res;
	rwhp_pkg::rwhp_result_t res_q;

	assign advance  = valid_s1 && (!m_tvalid || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1.func      <= s_tuser;
			item_s1.data_byte <= s_tdata;
		end
	end

	rwhp_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.item      (item_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (!m_tvalid || m_tready) begin
			m_tvalid <= advance && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_valid) begin
			res_q <= res;
		end
	end

	assign m_tuser = res_q.status;
	assign m_tdata = {res_q.data_size, res_q.data_offset, res_q.bits_per_sample,
		res_q.block_align, res_q.channel_count, res_q.sample_rate};

endmodule

>>> sim/riff_wave_header_parser_check.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// riff_wave_header_parser_check
// Watches both streams of the header parser. Every input transfer advances a
// private copy of the RIFF/WAVE header walk, and each output transfer is
// compared field by field with the oldest predicted header result.
// ----------------------------------------------------------------------------
module riff_wave_header_parser_check (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	input  logic         s_tready,
	input  logic [7:0]   s_tdata,   // [7:0] data_byte
	input  logic [1:0]   s_tuser,   // [1:0] func
	input  logic         m_tvalid,
	input  logic         m_tready,
	input  logic [143:0] m_tdata,   // [31:0] sample_rate, [47:32] channel_count,
	                                // [63:48] block_align, [79:64] bits_per_sample,
	                                // [111:80] data_offset, [143:112] data_size
	input  logic [2:0]   m_tuser,   // [2:0] status
	output int           mismatches,
	output int           pending,
	output int           headers_checked,
	output logic [4:0]   statuses_seen
);

	typedef enum logic [1:0] {WALK_HEADER, WALK_CHUNK, WALK_FMT, WALK_SKIP} walk_phase_t;

	walk_phase_t  phase;
	logic [31:0]  byte_pos, tag_sr, size_sr, skip_left, riff_left;
	logic [4:0]   field_idx;
	logic [15:0]  fmt_code, chans, align, bits;
	logic [31:0]  rate, offs, dlen;
	logic         done;
	rwhp_pkg::rwhp_result_t header_results_due[$];
	rwhp_pkg::rwhp_result_t want;
	int           mismatch_total = 0;
	int           checked_total = 0;
	logic [4:0]   seen_mask = '0;

	task automatic clear_walk();
		phase = WALK_HEADER;
		byte_pos = '0;
		field_idx = '0;
		tag_sr = '0;
		size_sr = '0;
		skip_left = '0;
		riff_left = '0;
		fmt_code = '0;
		rate = '0;
		chans = '0;
		align = '0;
		bits = '0;
		offs = '0;
		dlen = '0;
		done = 1'b0;
	endtask

	task automatic post_result(input logic [2:0] code);
		rwhp_pkg::rwhp_result_t r;
		logic ok;
		ok = (code == rwhp_pkg::ST_OK);
		r.status = code;
		r.sample_rate = ok ? rate : '0;
		r.channel_count = ok ? chans : '0;
		r.block_align = ok ? align : '0;
		r.bits_per_sample = ok ? bits : '0;
		r.data_offset = ok ? offs : '0;
		r.data_size = ok ? dlen : '0;
		header_results_due.push_back(r);
		done = 1'b1;
	endtask

	// RIFF size is charged 8 + chunk size and saturates at zero
	task automatic close_chunk(input logic [31:0] size, input logic [31:0] skip);
		logic [32:0] used;
		used = {1'b0, size} + 33'd8;
		if ({1'b0, riff_left} <= used)
			riff_left = '0;
		else
			riff_left = riff_left - used[31:0];
		if (riff_left == 0)
			post_result(rwhp_pkg::ST_RIFF_EXH);
		else if (skip == 0)
			phase = WALK_CHUNK;
		else begin
			phase = WALK_SKIP;
			skip_left = skip;
		end
	endtask

	task automatic walk_transfer(input logic [1:0] fn, input logic [7:0] b);
		logic [4:0] idx;
		idx = field_idx;
		if (fn == rwhp_pkg::FN_RESTART)
			clear_walk();
		else if (!done && fn == rwhp_pkg::FN_EOF)
			post_result(rwhp_pkg::ST_EARLY_EOF);
		else if (!done && fn == rwhp_pkg::FN_BYTE) begin
			byte_pos++;
			case (phase)
				WALK_HEADER: begin
					if (idx < 4 || idx >= 8)
						tag_sr = {b, tag_sr[31:8]};
					else
						size_sr = {b, size_sr[31:8]};
					field_idx = idx + 5'd1;
					if (idx == 3 && tag_sr != rwhp_pkg::TAG_RIFF)
						post_result(rwhp_pkg::ST_NOT_WAVE);
					else if (idx >= 11) begin
						if (tag_sr != rwhp_pkg::TAG_WAVE)
							post_result(rwhp_pkg::ST_NOT_WAVE);
						else begin
							riff_left = size_sr;
							field_idx = '0;
							phase = WALK_CHUNK;
							if (riff_left == 0)
								post_result(rwhp_pkg::ST_RIFF_EXH);
						end
					end
				end
				WALK_CHUNK: begin
					if (idx < 4)
						tag_sr = {b, tag_sr[31:8]};
					else
						size_sr = {b, size_sr[31:8]};
					field_idx = idx + 5'd1;
					if (idx >= 7) begin
						field_idx = '0;
						if (tag_sr == rwhp_pkg::TAG_DATA) begin
							offs = byte_pos;
							dlen = size_sr;
							if (offs != 0 && rate != 0)
								post_result(rwhp_pkg::ST_OK);
							else
								close_chunk(size_sr, size_sr);
						end else if (tag_sr == rwhp_pkg::TAG_FMT)
							phase = WALK_FMT;
						else
							close_chunk(size_sr, size_sr);
					end
				end
				WALK_FMT: begin
					if (idx < 2)
						fmt_code[8*idx[0] +: 8] = b;
					else if (idx < 4)
						chans[8*idx[0] +: 8] = b;
					else if (idx < 8)
						rate[8*idx[1:0] +: 8] = b;
					else if (idx >= 12 && idx < 14)
						align[8*idx[0] +: 8] = b;
					else if (idx >= 14)
						bits[8*idx[0] +: 8] = b;
					field_idx = idx + 5'd1;
					if (idx >= 15) begin
						field_idx = '0;
						if (fmt_code != rwhp_pkg::FMT_PCM)
							post_result(rwhp_pkg::ST_NOT_PCM);
						else if (offs != 0 && rate != 0)
							post_result(rwhp_pkg::ST_OK);
						else
							close_chunk(size_sr, (size_sr > 32'd16) ? size_sr - 32'd16 : '0);
					end
				end
				default: begin
					if (skip_left > 0)
						skip_left--;
					if (skip_left == 0)
						phase = WALK_CHUNK;
				end
			endcase
		end
	endtask

	task automatic check_field(input string name, input logic [31:0] want_v,
			input logic [31:0] got_v);
		if (got_v !== want_v) begin
			$error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want_v, got_v);
			mismatch_total++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_walk();
			header_results_due.delete();
		end else begin
			if (s_tvalid && s_tready)
				walk_transfer(s_tuser, s_tdata);
			if (m_tvalid && m_tready) begin
				if (header_results_due.size() == 0) begin
					$error("unexpected result transfer, status %0d", m_tuser);
					mismatch_total++;
				end else begin
					want = header_results_due.pop_front();
					check_field("status", want.status, m_tuser);
					check_field("sample_rate", want.sample_rate, m_tdata[31:0]);
					check_field("channel_count", want.channel_count, m_tdata[47:32]);
					check_field("block_align", want.block_align, m_tdata[63:48]);
					check_field("bits_per_sample", want.bits_per_sample, m_tdata[79:64]);
					check_field("data_offset", want.data_offset, m_tdata[111:80]);
					check_field("data_size", want.data_size, m_tdata[143:112]);
					checked_total++;
					if (m_tuser <= rwhp_pkg::ST_RIFF_EXH)
						seen_mask[m_tuser] = 1'b1;
				end
			end
		end
		pending <= header_results_due.size();
		mismatches <= mismatch_total;
		headers_checked <= checked_total;
		statuses_seen <= seen_mask;
	end

endmodule

>>> sim/riff_wave_header_parser_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// riff_wave_header_parser_test
// Feeds the header parser a short directed sequence, then random WAV files
// (mostly well formed, with corrupted tags, odd fmt sizes, small RIFF sizes,
// truncation and noise), under bursty input and stalling output.
// ----------------------------------------------------------------------------
module riff_wave_header_parser_test;

	localparam int ItemTarget = 1700;
	localparam int IdleLimit  = 2000;
	localparam int HoldStart  = 1000;
	localparam int HoldCycles = 300;

	localparam logic [1:0] FnByte    = rwhp_pkg::FN_BYTE;
	localparam logic [1:0] FnEof     = rwhp_pkg::FN_EOF;
	localparam logic [1:0] FnRestart = rwhp_pkg::FN_RESTART;

	// early end of file, bad tag, zero RIFF size
	localparam logic [9:0] OpeningItems [24] = '{
		{FnRestart, 8'h00}, {FnEof, 8'h00}, {FnEof, 8'hFF}, {FnByte, 8'hFF},
		{FnEof | FnRestart, 8'hFF}, {FnRestart, 8'hFF},
		{FnByte, 8'h52}, {FnByte, 8'h49}, {FnByte, 8'h46}, {FnByte, 8'h58},
		{FnRestart, 8'h00},
		{FnByte, 8'h52}, {FnByte, 8'h49}, {FnByte, 8'h46}, {FnByte, 8'h46},
		{FnByte, 8'h00}, {FnByte, 8'h00}, {FnByte, 8'h00}, {FnByte, 8'h00},
		{FnByte, 8'h57}, {FnByte, 8'h41}, {FnByte, 8'h56}, {FnByte, 8'h45},
		{FnRestart, 8'h00}
	};

	logic         clk = 1'b0;
	logic         arst_n;
	logic         s_tvalid, s_tready;
	logic [7:0]   s_tdata;
	logic [1:0]   s_tuser;
	logic         m_tvalid, m_tready;
	logic [143:0] m_tdata;
	logic [2:0]   m_tuser;
	int           mismatches, pending, headers_checked;
	logic [4:0]   statuses_seen;
	int           items_sent = 0;
	int           files_sent = 0;
	int           burst_left = 1;
	int           idle_cycles = 0;
	logic [7:0]   file_bytes[$];

	always #5 clk = ~clk;

	riff_wave_header_parser dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	riff_wave_header_parser_check header_check (
		.clk             (clk),
		.arst_n          (arst_n),
		.s_tvalid        (s_tvalid),
		.s_tready        (s_tready),
		.s_tdata         (s_tdata),
		.s_tuser         (s_tuser),
		.m_tvalid        (m_tvalid),
		.m_tready        (m_tready),
		.m_tdata         (m_tdata),
		.m_tuser         (m_tuser),
		.mismatches      (mismatches),
		.pending         (pending),
		.headers_checked (headers_checked),
		.statuses_seen   (statuses_seen)
	);

	task automatic send_item(input logic [1:0] fn, input logic [7:0] b);
		s_tvalid <= 1'b1;
		s_tuser <= fn;
		s_tdata <= b;
		do @(posedge clk); while (!s_tready);
		items_sent++;
		burst_left--;
		if (burst_left <= 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			burst_left = ($urandom_range(0, 4) == 0) ? 150 : $urandom_range(1, 16);
		end
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	task automatic push_word(input logic [31:0] v, input int nbytes);
		for (int k = 0; k < nbytes; k++)
			file_bytes.push_back(v[8*k +: 8]);
	endtask

	task automatic push_filler(input int n);
		repeat (n) file_bytes.push_back(8'($urandom));
	endtask

	task automatic push_junk_chunk();
		logic [31:0] size;
		size = $urandom_range(0, 9);
		push_word($urandom, 4);
		push_word(size, 4);
		push_filler(size);
	endtask

	// short, exact and oversized fmt chunks; non-PCM and zero rate now and then
	task automatic push_fmt_chunk();
		logic [31:0] size;
		case ($urandom_range(0, 5))
			0: size = $urandom_range(0, 15);
			1: size = $urandom_range(17, 24);
			default: size = 32'd16;
		endcase
		push_word(rwhp_pkg::TAG_FMT, 4);
		push_word(size, 4);
		push_word(($urandom_range(0, 7) == 0) ? $urandom : rwhp_pkg::FMT_PCM, 2);
		push_word($urandom, 2);
		push_word(($urandom_range(0, 7) == 0) ? 32'd0 : $urandom, 4);
		push_word($urandom, 4);
		push_word($urandom, 4);
		if (size > 16)
			push_filler(size - 16);
	endtask

	task automatic push_data_chunk(input logic short_body);
		logic [31:0] size;
		if (short_body)
			size = $urandom_range(0, 6);
		else
			size = ($urandom_range(0, 1) == 0) ? $urandom : $urandom_range(0, 40);
		push_word(rwhp_pkg::TAG_DATA, 4);
		push_word(size, 4);
		push_filler((size < 6) ? size : 6);
	endtask

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IdleLimit) begin
			$display("watchdog: no transfer for %0d cycles", IdleLimit);
			$display("status: fail");
			$finish;
		end
	end

	// output side: changing stall pattern plus one long hold-off
	initial begin
		int cyc;
		int mode;
		cyc = 0;
		mode = 0;
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			cyc++;
			if (cyc % 256 == 0)
				mode = $urandom_range(0, 3);
			if (cyc >= HoldStart && cyc < HoldStart + HoldCycles)
				m_tready <= 1'b0;
			else begin
				case (mode)
					0: m_tready <= 1'b1;
					1: m_tready <= ($urandom_range(0, 1) == 0);
					2: m_tready <= (cyc % 4 == 0);
					default: m_tready <= ($urandom_range(0, 7) != 0);
				endcase
			end
		end
	end

	initial begin
		logic [31:0] riff_size;
		int cut;
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= FnByte;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int k = 0; k < $size(OpeningItems); k++)
			send_item(OpeningItems[k][9:8], OpeningItems[k][7:0]);

		while (items_sent < ItemTarget) begin
			file_bytes.delete();
			if ($urandom_range(0, 15) == 0)
				push_filler($urandom_range(0, 20));
			else begin
				case ($urandom_range(0, 19))
					0: riff_size = '0;
					1: riff_size = 32'hFFFF_FFFF;
					2, 3: riff_size = $urandom_range(1, 60);
					default: riff_size = $urandom_range(100, 100000);
				endcase
				push_word(($urandom_range(0, 15) == 0) ? $urandom : rwhp_pkg::TAG_RIFF, 4);
				push_word(riff_size, 4);
				push_word(($urandom_range(0, 15) == 0) ? $urandom : rwhp_pkg::TAG_WAVE, 4);
				repeat ($urandom_range(0, 2)) push_junk_chunk();
				if ($urandom_range(0, 3) == 0) begin
					push_data_chunk(1'b1);
					repeat ($urandom_range(0, 1)) push_junk_chunk();
					push_fmt_chunk();
				end else begin
					push_fmt_chunk();
					repeat ($urandom_range(0, 1)) push_junk_chunk();
					push_data_chunk(1'b0);
				end
				push_filler($urandom_range(0, 4));
			end

			cut = file_bytes.size();
			if ($urandom_range(0, 7) == 0)
				cut = $urandom_range(0, file_bytes.size());
			send_item(FnRestart, 8'($urandom));
			for (int k = 0; k < cut; k++) begin
				if ($urandom_range(0, 39) == 0)
					send_item(FnEof | FnRestart, 8'($urandom));
				send_item(FnByte, file_bytes[k]);
			end
			if ($urandom_range(0, 5) != 0)
				send_item(FnEof, 8'($urandom));
			if ($urandom_range(0, 5) == 0)
				send_item(FnByte, 8'($urandom));
			files_sent++;

			if (files_sent == 3 || $urandom_range(0, 7) == 0)
				drain_results();
		end

		drain_results();
		repeat (8) @(posedge clk);
		$display("sent %0d input transfers over %0d files, %0d results checked",
			items_sent, files_sent, headers_checked);
		$display("result codes returned (one bit per code, ok at bit 0): %05b", statuses_seen);
		if (mismatches == 0 && pending == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

>>> filelist.f
rtl/core/rwhp_pkg.sv
rtl/core/rwhp_core.sv
rtl/core/riff_wave_header_parser.sv
sim/riff_wave_header_parser_check.sv
sim/riff_wave_header_parser_test.sv
